### hw/rtl/point_pose_transform_cube_binning_unit_macros.svh
// assertion macros of the point transform and cube binning unit
`ifndef POINT_POSE_TRANSFORM_CUBE_BINNING_UNIT_MACROS_SVH
`define POINT_POSE_TRANSFORM_CUBE_BINNING_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PPCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppcb check failed");

// implication after a fixed number of cycles
`define PPCB_ASSERT_LAT(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("ppcb latency check failed");

`endif

### hw/rtl/ppcb_pkg.sv
// package: types, constants and helper functions of the point transform and binning unit
`default_nettype none

package ppcb_pkg;

  localparam int unsigned GRID_WIDTH  = 21;
  localparam int unsigned GRID_HEIGHT = 21;
  localparam int unsigned GRID_DEPTH  = 11;
  localparam int unsigned CUBE_SIZE_M = 50;

  localparam int unsigned LATENCY    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CENTER_W   = 24;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned IDX_W      = 13;
  localparam int unsigned PROD_W     = 34;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned OFF_W      = 33;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned RECIP_W    = 33;
  localparam int unsigned REM_W      = MAG_W + 11;
  localparam int unsigned CUBE_W     = 18;
  localparam int unsigned FULL_IDX_W = 26;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / CUBE_SIZE_M);
  localparam logic signed [OFF_W-1:0] HALF_CUBE = OFF_W'(CUBE_SIZE_M * 32768);

  localparam logic signed [31:0] Q_ONE   = 32'sh4000_0000;
  localparam logic signed [31:0] Q_NEG   = 32'shC000_0000;
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
  localparam logic signed [33:0] R_MAX   = 34'sh0_FFFF_FFFF;
  localparam logic signed [33:0] R_MIN   = 34'sh3_0000_0001;
  localparam logic signed [SUM_W-1:0] W32_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] W32_MIN = 36'shF_8000_0000;
  localparam logic [CENTER_W-1:0] CENTER_RESET = 24'h05_0A0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_W,
    CFG_ROT_X,
    CFG_ROT_Y,
    CFG_ROT_Z,
    CFG_TRANS_X,
    CFG_TRANS_Y,
    CFG_TRANS_Z,
    CFG_GRID_CENTER
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        point_intensity;
  } point_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [31:0]        out_intensity;
    logic [IDX_W-1:0]   cube_index;
    logic               in_grid;
  } result_t;

  // row-major rotation matrix, each entry signed q.30
  typedef logic [2:0][2:0][32:0] rot_mat_t;

  typedef struct packed {
    logic [2:0][31:0]       trans;
    logic [2:0][CELL_W-1:0] center;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0]      world;
    logic [2:0][OFF_W-1:0] off;
    logic [31:0]           intensity;
  } rot_stage_t;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < Q_NEG) begin
      r = Q_NEG;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [32:0] rentry(input logic signed [63:0] v);
    logic signed [33:0] sh;
    logic signed [32:0] r;
    sh = v[63:30];
    if (sh > R_MAX) begin
      r = R_MAX[32:0];
    end else if (sh < R_MIN) begin
      r = R_MIN[32:0];
    end else begin
      r = sh[32:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] s);
    logic signed [31:0] r;
    if (s > W32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < W32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/point_pose_transform_cube_binning_unit.sv
// top level of the point transform and cube binning unit
// done_o is raised once a taken start has passed through all the register stages.
// Throughput: one item per clock, set by eight register stages with a multiplier row each
// where needed; results leave on a one-cycle strobe and are never held off.
// Reset: identity rotation, zero translation, centre cubes 10/10/5, items in flight dropped;
// busy is high during reset and until the ready register is set after it.
`default_nettype none

`include "point_pose_transform_cube_binning_unit_macros.svh"

module point_pose_transform_cube_binning_unit
  import ppcb_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire point_t          point_i,
  output logic                 done_o,
  output result_t              result_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic       ready_q;
  logic       acc;
  cfg_t       cfg;
  rot_mat_t   mat;
  logic       rot_vld;
  rot_stage_t rot_stage;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= 1'b1;
    end
  end

  assign busy = ~ready_q;
  assign acc  = start & ready_q;

  ppcb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .mat_o       (mat)
  );

  ppcb_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .point_i (point_i),
    .mat_i   (mat),
    .cfg_i   (cfg),
    .vld_o   (rot_vld),
    .stage_o (rot_stage)
  );

  ppcb_bin u_bin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (rot_vld),
    .stage_i  (rot_stage),
    .cfg_i    (cfg),
    .done_o   (done_o),
    .result_o (result_o)
  );

  `PPCB_ASSERT_LAT(a_done_after_start, start && !busy, LATENCY, done_o)
  `PPCB_ASSERT_IMP(a_start_before_done, done_o, $past(start && !busy, LATENCY))
  `PPCB_ASSERT_IMP(a_index_zero_outside, done_o && !result_o.in_grid, result_o.cube_index == '0)

endmodule

`default_nettype wire

### hw/rtl/ppcb_cfg.sv
// configuration registers and rotation matrix setup pipeline
`default_nettype none

module ppcb_cfg
  import ppcb_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i,
  output cfg_t                  cfg_o,
  output rot_mat_t              mat_o
);

  logic signed [31:0]   rot_q [4];
  logic signed [31:0]   trans_q [3];
  logic [CENTER_W-1:0]  center_q;
  logic signed [63:0]   sq_q [9];
  rot_mat_t             mat_q;

  // quaternion components are clamped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= Q_ONE;
      rot_q[1]   <= '0;
      rot_q[2]   <= '0;
      rot_q[3]   <= '0;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
      center_q   <= CENTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROT_W:       rot_q[0]   <= clamp_q($signed(cfg_wdata_i));
        CFG_ROT_X:       rot_q[1]   <= clamp_q($signed(cfg_wdata_i));
        CFG_ROT_Y:       rot_q[2]   <= clamp_q($signed(cfg_wdata_i));
        CFG_ROT_Z:       rot_q[3]   <= clamp_q($signed(cfg_wdata_i));
        CFG_TRANS_X:     trans_q[0] <= $signed(cfg_wdata_i);
        CFG_TRANS_Y:     trans_q[1] <= $signed(cfg_wdata_i);
        CFG_TRANS_Z:     trans_q[2] <= $signed(cfg_wdata_i);
        CFG_GRID_CENTER: center_q   <= cfg_wdata_i[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // pair products: xx yy zz xy xz yz wx wy wz
  always_ff @(posedge clk_i) begin
    sq_q[0] <= 64'(rot_q[1]) * 64'(rot_q[1]);
    sq_q[1] <= 64'(rot_q[2]) * 64'(rot_q[2]);
    sq_q[2] <= 64'(rot_q[3]) * 64'(rot_q[3]);
    sq_q[3] <= 64'(rot_q[1]) * 64'(rot_q[2]);
    sq_q[4] <= 64'(rot_q[1]) * 64'(rot_q[3]);
    sq_q[5] <= 64'(rot_q[2]) * 64'(rot_q[3]);
    sq_q[6] <= 64'(rot_q[0]) * 64'(rot_q[1]);
    sq_q[7] <= 64'(rot_q[0]) * 64'(rot_q[2]);
    sq_q[8] <= 64'(rot_q[0]) * 64'(rot_q[3]);
  end

  always_ff @(posedge clk_i) begin
    mat_q[0][0] <= rentry(ONE_Q60 - ((sq_q[1] + sq_q[2]) <<< 1));
    mat_q[0][1] <= rentry((sq_q[3] - sq_q[8]) <<< 1);
    mat_q[0][2] <= rentry((sq_q[4] + sq_q[7]) <<< 1);
    mat_q[1][0] <= rentry((sq_q[3] + sq_q[8]) <<< 1);
    mat_q[1][1] <= rentry(ONE_Q60 - ((sq_q[0] + sq_q[2]) <<< 1));
    mat_q[1][2] <= rentry((sq_q[5] - sq_q[6]) <<< 1);
    mat_q[2][0] <= rentry((sq_q[4] - sq_q[7]) <<< 1);
    mat_q[2][1] <= rentry((sq_q[5] + sq_q[6]) <<< 1);
    mat_q[2][2] <= rentry(ONE_Q60 - ((sq_q[0] + sq_q[1]) <<< 1));
  end

  assign mat_o = mat_q;

  always_comb begin
    cfg_o.trans[0]  = trans_q[0];
    cfg_o.trans[1]  = trans_q[1];
    cfg_o.trans[2]  = trans_q[2];
    cfg_o.center[0] = center_q[7:0];
    cfg_o.center[1] = center_q[15:8];
    cfg_o.center[2] = center_q[23:16];
  end

endmodule

`default_nettype wire

### hw/rtl/ppcb_rotate.sv
// rotation, translation and saturation stages
`default_nettype none

module ppcb_rotate
  import ppcb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         acc_i,
  input  wire point_t point_i,
  input  wire rot_mat_t mat_i,
  input  wire cfg_t   cfg_i,
  output logic        vld_o,
  output rot_stage_t  stage_o
);

  logic [4:0]              vld_q;
  logic signed [31:0]      p1_q [3];
  logic signed [31:0]      p2_q [3];
  logic [31:0]             int1_q, int2_q, int3_q, int4_q;
  logic signed [64:0]      full [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [SUM_W-1:0] sum_d [3];
  logic signed [SUM_W-1:0] sum_q [3];
  rot_stage_t              stage_d;
  rot_stage_t              stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], acc_i};
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        full[a][b] = 65'($signed(mat_i[a][b])) * 65'(p2_q[b]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_d[a] = SUM_W'($signed(cfg_i.trans[a])) + SUM_W'(prod_q[a][0])
               + SUM_W'(prod_q[a][1]) + SUM_W'(prod_q[a][2]);
    end
  end

  always_comb begin
    stage_d.intensity = int4_q;
    for (int a = 0; a < 3; a++) begin
      stage_d.world[a] = sat32(sum_q[a]);
      stage_d.off[a]   = OFF_W'($signed(stage_d.world[a])) + HALF_CUBE;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q[0] <= point_i.point_x;
    p1_q[1] <= point_i.point_y;
    p1_q[2] <= point_i.point_z;
    int1_q  <= point_i.point_intensity;
    // matrix setup slot
    p2_q    <= p1_q;
    int2_q  <= int1_q;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        prod_q[a][b] <= full[a][b][63:30];
      end
    end
    int3_q  <= int2_q;
    sum_q   <= sum_d;
    int4_q  <= int3_q;
    stage_q <= stage_d;
  end

  assign vld_o   = vld_q[4];
  assign stage_o = stage_q;

endmodule

`default_nettype wire

### hw/rtl/ppcb_bin.sv
// cube coordinate division, range check and linear index stages
`default_nettype none

module ppcb_bin
  import ppcb_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             vld_i,
  input  wire rot_stage_t stage_i,
  input  wire cfg_t       cfg_i,
  output logic            done_o,
  output result_t         result_o
);

  logic [2:0]              vld_q;
  logic [2:0]              neg_d, neg_q;
  logic [MAG_W-1:0]        mag_d [3];
  logic [MAG_W-1:0]        mag_q [3];
  logic [MAG_W-1:0]        qe_d [3];
  logic [MAG_W-1:0]        qe_q [3];
  logic signed [OFF_W-1:0] off_s [3];
  logic signed [OFF_W-1:0] abs_s [3];
  logic [MAG_W+RECIP_W-1:0] qp [3];
  logic [REM_W-1:0]        rem [3];
  logic [MAG_W-1:0]        quo [3];
  logic [CUBE_W-1:0]       cube_d [3];
  logic [CUBE_W-1:0]       cube_q [3];
  logic [2:0][31:0]        world6_q, world7_q;
  logic [31:0]             int6_q, int7_q;
  logic [2:0]              ok;
  logic [FULL_IDX_W-1:0]   full_idx;
  result_t                 res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // magnitude and reciprocal estimate of the quotient
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      off_s[a] = $signed(stage_i.off[a]);
      neg_d[a] = off_s[a][OFF_W-1];
      abs_s[a] = neg_d[a] ? -off_s[a] : off_s[a];
      mag_d[a] = abs_s[a][31:16];
      qp[a]    = (MAG_W+RECIP_W)'(mag_d[a]) * (MAG_W+RECIP_W)'(RECIP);
      qe_d[a]  = qp[a][MAG_W+31:32];
    end
  end

  // correction, floor for negatives, centre offset
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem[a]    = REM_W'(mag_q[a]) - REM_W'(qe_q[a]) * REM_W'(CUBE_SIZE_M);
      quo[a]    = qe_q[a] + MAG_W'(rem[a] >= REM_W'(CUBE_SIZE_M));
      cube_d[a] = (neg_q[a] ? ~CUBE_W'(quo[a]) : CUBE_W'(quo[a]))
                + CUBE_W'(cfg_i.center[a]);
    end
  end

  always_comb begin
    ok[0] = !cube_q[0][CUBE_W-1] && (cube_q[0] < CUBE_W'(GRID_WIDTH));
    ok[1] = !cube_q[1][CUBE_W-1] && (cube_q[1] < CUBE_W'(GRID_HEIGHT));
    ok[2] = !cube_q[2][CUBE_W-1] && (cube_q[2] < CUBE_W'(GRID_DEPTH));
    full_idx = FULL_IDX_W'(cube_q[0][CELL_W-1:0])
             + FULL_IDX_W'(GRID_WIDTH) * FULL_IDX_W'(cube_q[1][CELL_W-1:0])
             + FULL_IDX_W'(GRID_WIDTH * GRID_HEIGHT) * FULL_IDX_W'(cube_q[2][CELL_W-1:0]);
    res_d.world_x       = world7_q[0];
    res_d.world_y       = world7_q[1];
    res_d.world_z       = world7_q[2];
    res_d.out_intensity = int7_q;
    res_d.in_grid       = &ok;
    res_d.cube_index    = (&ok) ? full_idx[IDX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    qe_q     <= qe_d;
    world6_q <= stage_i.world;
    int6_q   <= stage_i.intensity;
    cube_q   <= cube_d;
    world7_q <= world6_q;
    int7_q   <= int6_q;
    res_q    <= res_d;
  end

  assign done_o   = vld_q[2];
  assign result_o = res_q;

endmodule

`default_nettype wire
